// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame parser modules.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/isfp_pkg.sv =====
// Shared types and constants for the IMU serial frame parser.
// No dependencies; every module of the parser imports this package.
package isfp_pkg;

    // Frame layout: sync, kind, six used data bytes, two unused, checksum.
    localparam int FRAME_LAST_POS = 10;
    localparam int DATA_FIRST_POS = 2;
    localparam int NUM_DATA_BYTES = 6;
    localparam int NUM_KINDS      = 4;

    // Register reset values.
    localparam logic [7:0] SYNC_RESET       = 8'h55;
    localparam logic [7:0] FIRST_KIND_RESET = 8'h51;

    // Configuration register indexes.
    localparam int         CFG_INDEX_W    = 8;
    localparam logic [7:0] CFG_SYNC_BYTE  = 8'd0;
    localparam logic [7:0] CFG_FIRST_KIND = 8'd1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_KIND     = 2'd2;

    // Stream widths.
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 48;
    localparam int TUSER_OUT_W = 4;

    typedef logic [7:0] byte_t;
    typedef logic [NUM_KINDS-1:0] kind_mask_t;

    // A frame as handed from the assembler to the result generator.
    typedef struct packed {
        logic               done;
        logic               chk_ok;
        byte_t              kind_byte;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } frame_t;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         kind;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic               set_complete;
    } result_t;

endpackage

// ===== rtl/isfp_frame_asm.sv =====
// Frame assembler: byte counter, sync check, running checksum and data byte capture.
// Depends on isfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isfp_frame_asm (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  isfp_pkg::byte_t rx_byte,
    input  isfp_pkg::byte_t sync_byte,
    output isfp_pkg::frame_t frame
);
    import isfp_pkg::*;

    logic [3:0] count_reg;
    logic [3:0] count_next;
    byte_t      byte0_reg;
    byte_t      kind_reg;
    byte_t      sum_reg;
    byte_t      data_reg [NUM_DATA_BYTES];
    logic       first_ok;
    logic       last_byte;

    // The first byte is checked on its arrival and again with every later byte,
    // since the sync value may be rewritten between a frame's bytes.
    always_comb begin
        first_ok  = (count_reg == 4'd0) ? (rx_byte == sync_byte) : (byte0_reg == sync_byte);
        last_byte = (count_reg == 4'(FRAME_LAST_POS));
        count_next = count_reg;
        if (step) begin
            if (!first_ok || last_byte) begin
                count_next = 4'd0;
            end else begin
                count_next = count_reg + 4'd1;
            end
        end
    end

    // Byte counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Capture of the frame bytes that are needed later and the running sum.
    always_ff @(posedge aclk) begin
        if (step) begin
            if (count_reg == 4'd0) begin
                byte0_reg <= rx_byte;
                sum_reg   <= rx_byte;
            end else begin
                sum_reg <= sum_reg + rx_byte;
            end
            if (count_reg == 4'd1) begin
                kind_reg <= rx_byte;
            end
            for (int i = 0; i < NUM_DATA_BYTES; i++) begin
                if (count_reg == 4'(DATA_FIRST_POS + i)) begin
                    data_reg[i] <= rx_byte;
                end
            end
        end
    end

    // The checksum byte closes the frame; the sum then covers bytes zero to nine.
    always_comb begin
        frame.done      = step && first_ok && last_byte;
        frame.chk_ok    = (sum_reg == rx_byte);
        frame.kind_byte = kind_reg;
        frame.axis_x    = {data_reg[1], data_reg[0]};
        frame.axis_y    = {data_reg[3], data_reg[2]};
        frame.axis_z    = {data_reg[5], data_reg[4]};
    end

    `ASSERT_IMPL(a_count_range, 1'b1, count_reg <= 4'(FRAME_LAST_POS), "byte count past frame end")
    `ASSERT_NEXT(a_done_restarts, frame.done, count_reg == 4'd0, "count not cleared after frame")
    `ASSERT_NEXT(a_bad_sync_drops, step && count_reg == 4'd0 && rx_byte != sync_byte,
                 count_reg == 4'd0, "byte without sync started a frame")

endmodule

// ===== rtl/isfp_result_gen.sv =====
// Result generator: kind decode, set tracking and result field selection.
// Depends on isfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isfp_result_gen (
    input  logic              aclk,
    input  logic              aresetn,
    input  isfp_pkg::frame_t  frame,
    input  isfp_pkg::byte_t   first_kind_code,
    output logic              res_valid,
    output isfp_pkg::result_t result
);
    import isfp_pkg::*;

    kind_mask_t awaiting_reg;
    kind_mask_t awaiting_next;
    kind_mask_t arrived;
    kind_mask_t remaining;
    byte_t      kind_offset;
    logic [1:0] kind_idx;
    logic       kind_bad;

    // Kind decode: offset from the first kind code, wrapping modulo 256.
    always_comb begin
        kind_offset = frame.kind_byte - first_kind_code;
        kind_idx    = kind_offset[1:0];
        arrived     = kind_mask_t'(1) << kind_idx;
        remaining   = awaiting_reg & ~arrived;
        kind_bad    = (kind_offset[7:2] != 6'd0) || ((awaiting_reg & arrived) == '0);
    end

    // Result fields; unknown or repeated kinds report nothing but their status.
    always_comb begin
        res_valid = frame.done;
        result    = '0;
        awaiting_next = awaiting_reg;
        if (kind_bad) begin
            result.status = STATUS_KIND;
        end else begin
            result.kind = kind_idx;
            if (frame.chk_ok) begin
                result.status = STATUS_OK;
                result.axis_x = frame.axis_x;
                result.axis_y = frame.axis_y;
                result.axis_z = frame.axis_z;
            end else begin
                result.status = STATUS_CHECKSUM;
            end
            result.set_complete = (remaining == '0);
            if (frame.done) begin
                awaiting_next = (remaining == '0) ? '1 : remaining;
            end
        end
    end

    // Set of kinds still awaited.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg <= '1;
        end else begin
            awaiting_reg <= awaiting_next;
        end
    end

    `ASSERT_IMPL(a_set_never_empty, 1'b1, awaiting_reg != '0, "awaiting set is empty")
    `ASSERT_NEXT(a_complete_refills, frame.done && result.set_complete,
                 awaiting_reg == '1, "set not refilled after completion")
    `ASSERT_NEXT(a_bad_kind_keeps_set, frame.done && kind_bad,
                 $stable(awaiting_reg), "rejected kind changed the set")

endmodule

// ===== rtl/imu_serial_frame_parser_core.sv =====
// Top level of the IMU serial frame parser: input register, config registers,
// output register. Depends on isfp_pkg, isfp_frame_asm, isfp_result_gen, assert_macros.svh.
//
//  Channel   Direction  Payload
//  s_        in         tdata[7:0] rx_byte
//  m_        out        tdata axis_x/y/z, tuser status/kind, tlast set_complete
//  cfg_      in         cfg_index register number, cfg_data register value
//
// Bytes pass through the input register and results through the output register, which
// takes a result in the same cycle as its checksum byte moves on from the input register.
// One byte per cycle unless stalled; the output register is the only backpressure point.
// A byte waits in the input register while an undelivered result blocks the output.
// Reset is synchronous; it clears the byte counter, refills the set of awaited kinds,
// both valid flags and restores the register defaults.
`include "assert_macros.svh"

module imu_serial_frame_parser_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Received bytes.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [isfp_pkg::TDATA_IN_W-1:0]    s_tdata,   // [7:0] rx_byte
    // Results.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [isfp_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [15:0] axis_x, [31:16] axis_y,
                                                          // [47:32] axis_z
    output logic [isfp_pkg::TUSER_OUT_W-1:0]   m_tuser,   // [1:0] status, [3:2] kind
    output logic                               m_tlast,   // set_complete
    // Register writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [isfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                         cfg_data
);
    import isfp_pkg::*;

    logic    in_valid_reg;
    byte_t   in_byte_reg;
    byte_t   sync_reg;
    byte_t   first_kind_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    logic    advance;
    logic    res_valid;
    frame_t  frame;
    result_t result;

    // A byte moves on whenever the output register can take a result.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg       <= SYNC_RESET;
            first_kind_reg <= FIRST_KIND_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SYNC_BYTE:  sync_reg       <= cfg_data;
                CFG_FIRST_KIND: first_kind_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    isfp_frame_asm u_frame_asm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .sync_byte (sync_reg),
        .frame     (frame)
    );

    isfp_result_gen u_result_gen (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .frame           (frame),
        .first_kind_code (first_kind_reg),
        .res_valid       (res_valid),
        .result          (result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_result_reg <= result;
        end
    end

    // Result packing onto the stream.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_result_reg.axis_z, out_result_reg.axis_y, out_result_reg.axis_x};
    assign m_tuser  = {out_result_reg.kind, out_result_reg.status};
    assign m_tlast  = out_result_reg.set_complete;

    `ASSERT_IMPL(a_kind_err_clean, out_valid_reg && out_result_reg.status == STATUS_KIND,
                 out_result_reg.kind == 2'd0 && out_result_reg.axis_x == 16'sd0 &&
                 out_result_reg.axis_y == 16'sd0 && out_result_reg.axis_z == 16'sd0 &&
                 !out_result_reg.set_complete, "kind error item carries data")
    `ASSERT_IMPL(a_chk_err_clean, out_valid_reg && out_result_reg.status == STATUS_CHECKSUM,
                 out_result_reg.axis_x == 16'sd0 && out_result_reg.axis_y == 16'sd0 &&
                 out_result_reg.axis_z == 16'sd0, "checksum error item carries data")
    `ASSERT_NEXT(a_result_loaded, advance && res_valid, out_valid_reg,
                 "finished frame produced no item")

endmodule
